// ===== rtl/core/ehamt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the handle allocator.
package ehamt_pkg;

    localparam int ENTITY_SLOTS_DEF   = 256;
    localparam int COMPONENT_BITS_DEF = 32;

    localparam int OPCODE_W   = 3;
    localparam int ENTITY_W   = 8;
    localparam int COMP_W     = 5;
    localparam int HANDLE_W   = 9;
    localparam int STATUS_W   = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int COUNT_W    = 5;
    localparam int WIDE_W     = 17;

    localparam logic [OPCODE_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_DESTROY = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_ADD     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_HAS     = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_PURGE   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ENTITY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_COMPONENT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_REGISTERED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL           = 3'd5;

    localparam logic [HANDLE_W-1:0] NO_HANDLE = 9'd256;

    localparam logic [CFG_INDEX_W-1:0] CFG_REG_MASK  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REG_COUNT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PURGE,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic step;
        logic drain;
    } cmd_t;

    typedef struct packed {
        logic purge_go;
        logic purge_last;
    } sts_t;

endpackage

// ===== rtl/core/ehamt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences execute and the purge sweep.
module ehamt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ehamt_pkg::sts_t  sts,
    output logic             busy,
    output ehamt_pkg::cmd_t  cmd
);
    import ehamt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = sts.purge_go ? S_PURGE : S_IDLE;
            end
            S_PURGE:
            begin
                if (sts.purge_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy        = 1'b1;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.step    = 1'b0;
        cmd.drain   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_PURGE:
            begin
                cmd.step = 1'b1;
            end
            S_DRAIN:
            begin
                cmd.drain = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/core/ehamt_dp.sv =====
`timescale 1ns / 1ps
// Datapath: free stack, per-slot live flag and mask memory, counters and result registers.
module ehamt_dp #(
    parameter int ENTITY_SLOTS   = ehamt_pkg::ENTITY_SLOTS_DEF,
    parameter int COMPONENT_BITS = ehamt_pkg::COMPONENT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ehamt_pkg::cmd_t                     cmd,
    output ehamt_pkg::sts_t                     sts,
    input  logic [ehamt_pkg::OPCODE_W-1:0]      opcode,
    input  logic [ehamt_pkg::ENTITY_W-1:0]      entity,
    input  logic [ehamt_pkg::COMP_W-1:0]        component,
    input  logic                                cfg_we,
    input  logic [ehamt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ehamt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic                                done,
    output logic [ehamt_pkg::HANDLE_W-1:0]      handle,
    output logic [ehamt_pkg::STATUS_W-1:0]      status,
    output logic                                present
);
    import ehamt_pkg::*;

    localparam int IDX_W = (ENTITY_SLOTS > 1) ? $clog2(ENTITY_SLOTS) : 1;
    localparam int CNT_W = $clog2(ENTITY_SLOTS + 1);
    localparam int MEM_W = COMPONENT_BITS + 1;
    localparam int CB_W  = COMP_W + 1;

    // entry = {live, mask}
    logic [MEM_W-1:0] mask_mem [ENTITY_SLOTS];
    logic [IDX_W-1:0] stack_mem [ENTITY_SLOTS];

    logic [CFG_DATA_W-1:0] reg_mask_reg;
    logic [COUNT_W-1:0]    reg_count_reg;

    logic [OPCODE_W-1:0] op_reg;
    logic [ENTITY_W-1:0] ent_reg;
    logic [COMP_W-1:0]   comp_reg;

    logic [CNT_W-1:0] hw_reg;
    logic [CNT_W-1:0] hw_next;
    logic [CNT_W-1:0] fd_reg;
    logic [CNT_W-1:0] fd_next;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] scan_next;

    logic [MEM_W-1:0] mrd_reg;
    logic [IDX_W-1:0] srd_reg;

    logic                done_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                present_reg;

    logic [CNT_W-1:0] fd_m1;
    logic [CNT_W-1:0] hw_m1;
    logic [CNT_W-1:0] scan_m1;
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] ent_idx;

    logic                      ent_ok;
    logic                      comp_ok;
    logic                      comp_known;
    logic                      live;
    logic [COMPONENT_BITS-1:0] mask;
    logic [COMPONENT_BITS-1:0] bitsel;

    logic                purge_go;
    logic                res_load;
    logic [HANDLE_W-1:0] res_handle;
    logic [STATUS_W-1:0] res_status;
    logic                res_present;

    logic             mx_we;
    logic [IDX_W-1:0] mx_waddr;
    logic [MEM_W-1:0] mx_wdata;
    logic             m_we;
    logic [IDX_W-1:0] m_waddr;
    logic [MEM_W-1:0] m_wdata;
    logic             s_we;

    assign fd_m1   = fd_reg - CNT_W'(1);
    assign hw_m1   = hw_reg - CNT_W'(1);
    assign scan_m1 = scan_reg - CNT_W'(1);
    assign ent_idx = IDX_W'(ent_reg);
    assign raddr   = cmd.step ? scan_reg[IDX_W-1:0] : IDX_W'(entity);

    assign ent_ok = ({{(WIDE_W-ENTITY_W){1'b0}}, ent_reg} < WIDE_W'(hw_reg))
                 && ({{(WIDE_W-ENTITY_W){1'b0}}, ent_reg} < WIDE_W'(ENTITY_SLOTS));
    assign comp_ok    = (comp_reg < reg_count_reg) && ({1'b0, comp_reg} < CB_W'(COMPONENT_BITS));
    assign comp_known = reg_mask_reg[comp_reg];
    assign live       = mrd_reg[COMPONENT_BITS];
    assign mask       = mrd_reg[COMPONENT_BITS-1:0];
    assign bitsel     = COMPONENT_BITS'(1) << comp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_mask_reg  <= '0;
            reg_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REG_MASK:  reg_mask_reg  <= cfg_wdata;
                CFG_REG_COUNT: reg_count_reg <= cfg_wdata[COUNT_W-1:0];
                default:       reg_mask_reg  <= reg_mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            ent_reg  <= entity;
            comp_reg <= component;
        end
        mrd_reg <= mask_mem[raddr];
        srd_reg <= stack_mem[fd_m1[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            mask_mem[m_waddr] <= m_wdata;
        end
        if (s_we)
        begin
            stack_mem[fd_reg[IDX_W-1:0]] <= IDX_W'(ent_reg);
        end
    end

    always_comb
    begin
        res_handle  = NO_HANDLE;
        res_status  = ST_OK;
        res_present = 1'b0;
        mx_we       = 1'b0;
        mx_waddr    = ent_idx;
        mx_wdata    = '0;
        s_we        = 1'b0;
        hw_next     = hw_reg;
        fd_next     = fd_reg;
        purge_go    = 1'b0;
        if (cmd.exec)
        begin
            case (op_reg)
                OP_CREATE:
                begin
                    if (fd_reg != '0)
                    begin
                        res_handle = HANDLE_W'(srd_reg);
                        fd_next    = fd_m1;
                        mx_we      = 1'b1;
                        mx_waddr   = srd_reg;
                        mx_wdata   = {1'b1, {COMPONENT_BITS{1'b0}}};
                    end
                    else if (hw_reg < CNT_W'(ENTITY_SLOTS))
                    begin
                        res_handle = HANDLE_W'(hw_reg);
                        hw_next    = hw_reg + CNT_W'(1);
                        mx_we      = 1'b1;
                        mx_waddr   = hw_reg[IDX_W-1:0];
                        mx_wdata   = {1'b1, {COMPONENT_BITS{1'b0}}};
                    end
                    else
                    begin
                        res_status = ST_FULL;
                    end
                end
                OP_DESTROY:
                begin
                    res_handle = {1'b0, ent_reg};
                    if (!ent_ok)
                    begin
                        res_status = ST_BAD_ENTITY;
                    end
                    else if (!live)
                    begin
                        res_status = ST_ALREADY_FREE;
                    end
                    else
                    begin
                        if (fd_reg < CNT_W'(ENTITY_SLOTS))
                        begin
                            s_we    = 1'b1;
                            fd_next = fd_reg + CNT_W'(1);
                        end
                        mx_we    = 1'b1;
                        mx_wdata = '0;
                    end
                end
                OP_ADD, OP_REMOVE:
                begin
                    res_handle = {1'b0, ent_reg};
                    if (!ent_ok)
                    begin
                        res_status = ST_BAD_ENTITY;
                    end
                    else if (!comp_ok)
                    begin
                        res_status = ST_BAD_COMPONENT;
                    end
                    else if (!comp_known)
                    begin
                        res_status = ST_NOT_REGISTERED;
                    end
                    else
                    begin
                        mx_we    = 1'b1;
                        mx_wdata = {live, (op_reg == OP_ADD) ? (mask | bitsel)
                                                             : (mask & ~bitsel)};
                    end
                end
                OP_HAS:
                begin
                    res_handle = {1'b0, ent_reg};
                    if (!ent_ok)
                    begin
                        res_status = ST_BAD_ENTITY;
                    end
                    else if (!comp_ok)
                    begin
                        res_status = ST_BAD_COMPONENT;
                    end
                    else
                    begin
                        res_present = |(mask & bitsel);
                    end
                end
                OP_PURGE:
                begin
                    if (!comp_ok)
                    begin
                        res_status = ST_BAD_COMPONENT;
                    end
                    else if (!comp_known)
                    begin
                        res_status = ST_NOT_REGISTERED;
                    end
                    else
                    begin
                        purge_go = (hw_reg != '0);
                    end
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    // purge sweep: read slot scan, write back slot scan-1 with the bit cleared
    always_comb
    begin
        if (cmd.step || cmd.drain)
        begin
            m_we    = cmd.drain || (scan_reg != '0);
            m_waddr = scan_m1[IDX_W-1:0];
            m_wdata = {live, mask & ~bitsel};
        end
        else
        begin
            m_we    = mx_we;
            m_waddr = mx_waddr;
            m_wdata = mx_wdata;
        end
    end

    always_comb
    begin
        scan_next = scan_reg;
        if (cmd.exec)
        begin
            scan_next = '0;
        end
        else if (cmd.step)
        begin
            scan_next = scan_reg + CNT_W'(1);
        end
    end

    assign sts.purge_go   = purge_go;
    assign sts.purge_last = (scan_reg == hw_m1);
    assign res_load       = (cmd.exec && !purge_go) || cmd.drain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg   <= '0;
            fd_reg   <= '0;
            scan_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            hw_reg   <= hw_next;
            fd_reg   <= fd_next;
            scan_reg <= scan_next;
            done_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drain)
        begin
            handle_reg  <= NO_HANDLE;
            status_reg  <= ST_OK;
            present_reg <= 1'b0;
        end
        else if (res_load)
        begin
            handle_reg  <= res_handle;
            status_reg  <= res_status;
            present_reg <= res_present;
        end
    end

    assign done    = done_reg;
    assign handle  = handle_reg;
    assign status  = status_reg;
    assign present = present_reg;

    a_fd_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
        fd_reg <= hw_reg)
        else $error("free stack deeper than used slots");

    a_hw_range: assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= CNT_W'(ENTITY_SLOTS))
        else $error("high-water count past table size");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.exec || cmd.drain))
        else $error("result strobe without execute or purge end");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (scan_reg < hw_reg))
        else $error("purge sweep beyond used slots");

endmodule

// ===== rtl/core/entity_handle_allocator_mask_table.sv =====
`timescale 1ns / 1ps
// Top level of the entity handle allocator with per-handle component masks.
// One transaction at a time: start is taken when busy is low, and the result appears on
// handle/status/present with done high for one cycle, registered at the end of the execute
// state; start may be raised again in the cycle in which done is high, as every transaction
// other than a successful purge with used slots is complete by then: a registered read of the
// mask or stack memory followed by its write-back. A successful purge with at least one used
// slot sweeps every used slot through one read-modify-write per cycle on the mask memory
// write port; its result is registered in the drain state after the last slot, and busy
// stays high until then.
// The receiver cannot stall: done is a strobe and must be captured when it is high.
module entity_handle_allocator_mask_table #(
    parameter int ENTITY_SLOTS   = ehamt_pkg::ENTITY_SLOTS_DEF,
    parameter int COMPONENT_BITS = ehamt_pkg::COMPONENT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ehamt_pkg::OPCODE_W-1:0]    opcode,
    input  logic [ehamt_pkg::ENTITY_W-1:0]    entity,
    input  logic [ehamt_pkg::COMP_W-1:0]      component,
    output logic                              done,
    output logic [ehamt_pkg::HANDLE_W-1:0]    handle,
    output logic [ehamt_pkg::STATUS_W-1:0]    status,
    output logic                              present,
    input  logic                              cfg_we,
    input  logic [ehamt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ehamt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ehamt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ehamt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    ehamt_dp #(
        .ENTITY_SLOTS   (ENTITY_SLOTS),
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .opcode    (opcode),
        .entity    (entity),
        .component (component),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .handle    (handle),
        .status    (status),
        .present   (present)
    );

endmodule

// ===== tb/sv/entity_handle_allocator_mask_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the handle allocator: tracks allocation and mask state, predicts and compares results.
module entity_handle_allocator_mask_table_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [ehamt_pkg::OPCODE_W-1:0]    opcode,
    input  logic [ehamt_pkg::ENTITY_W-1:0]    entity,
    input  logic [ehamt_pkg::COMP_W-1:0]      component,
    input  logic                              done,
    input  logic [ehamt_pkg::HANDLE_W-1:0]    handle,
    input  logic [ehamt_pkg::STATUS_W-1:0]    status,
    input  logic                              present,
    input  logic                              cfg_we,
    input  logic [ehamt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ehamt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                                fail_count,
    output int                                pending,
    output int                                used_slots,
    output int                                stack_fill
);
    import ehamt_pkg::*;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
        logic                present;
    } outcome_t;

    outcome_t outcome_q[$];

    logic [CFG_DATA_W-1:0] reg_mask;
    logic [COUNT_W-1:0]    reg_count;
    logic [ENTITY_W-1:0]   free_stack [ENTITY_SLOTS_DEF];
    logic [31:0]           masks      [ENTITY_SLOTS_DEF];
    logic                  live       [ENTITY_SLOTS_DEF];
    int                    depth;
    int                    high_water;

    function automatic outcome_t run_command(input logic [OPCODE_W-1:0] op,
                                             input logic [ENTITY_W-1:0] ent,
                                             input logic [COMP_W-1:0]   comp);
        outcome_t r;
        logic     ent_ok;
        logic     comp_ok;
        logic     comp_reg;
        int       h;
        r.handle = NO_HANDLE;
        r.status = ST_OK;
        r.present = 1'b0;
        ent_ok = int'(ent) < high_water && int'(ent) < ENTITY_SLOTS_DEF;
        comp_ok = comp < reg_count && int'(comp) < COMPONENT_BITS_DEF;
        comp_reg = reg_mask[comp];
        case (op)
            OP_CREATE:
            begin
                h = -1;
                if (depth > 0)
                begin
                    depth--;
                    h = free_stack[depth];
                end
                else if (high_water < ENTITY_SLOTS_DEF)
                begin
                    h = high_water;
                    high_water++;
                end
                else
                    r.status = ST_FULL;
                if (h >= 0)
                begin
                    r.handle = HANDLE_W'(h);
                    live[h] = 1'b1;
                    masks[h] = '0;
                end
            end
            OP_DESTROY:
            begin
                r.handle = {1'b0, ent};
                if (!ent_ok)
                    r.status = ST_BAD_ENTITY;
                else if (!live[ent])
                    r.status = ST_ALREADY_FREE;
                else
                begin
                    if (depth < ENTITY_SLOTS_DEF)
                    begin
                        free_stack[depth] = ent;
                        depth++;
                    end
                    masks[ent] = '0;
                    live[ent] = 1'b0;
                end
            end
            OP_ADD, OP_REMOVE:
            begin
                r.handle = {1'b0, ent};
                if (!ent_ok)
                    r.status = ST_BAD_ENTITY;
                else if (!comp_ok)
                    r.status = ST_BAD_COMPONENT;
                else if (!comp_reg)
                    r.status = ST_NOT_REGISTERED;
                else
                    masks[ent][comp] = (op == OP_ADD);
            end
            OP_HAS:
            begin
                r.handle = {1'b0, ent};
                if (!ent_ok)
                    r.status = ST_BAD_ENTITY;
                else if (!comp_ok)
                    r.status = ST_BAD_COMPONENT;
                else
                    r.present = masks[ent][comp];
            end
            OP_PURGE:
            begin
                if (!comp_ok)
                    r.status = ST_BAD_COMPONENT;
                else if (!comp_reg)
                    r.status = ST_NOT_REGISTERED;
                else
                    for (int i = 0; i < high_water && i < ENTITY_SLOTS_DEF; i++)
                        masks[i][comp] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            outcome_q.delete();
            reg_mask = '0;
            reg_count = '0;
            depth = 0;
            high_water = 0;
            foreach (live[i])
                live[i] = 1'b0;
            fail_count = 0;
            pending = 0;
            used_slots = 0;
            stack_fill = 0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result handle=%0d status=%0d present=%0b",
                             $time, handle, status, present);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (handle !== want.handle || status !== want.status
                        || present !== want.present)
                    begin
                        fail_count++;
                        $display("%0t: expected h=%0d s=%0d p=%0b got h=%0d s=%0d p=%0b",
                                 $time, want.handle, want.status, want.present,
                                 handle, status, present);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_REG_MASK)
                    reg_mask = cfg_wdata;
                else if (cfg_index == CFG_REG_COUNT)
                    reg_count = cfg_wdata[COUNT_W-1:0];
            end
            if (start && !busy)
                outcome_q.push_back(run_command(opcode, entity, component));
            pending = outcome_q.size();
            used_slots = high_water;
            stack_fill = depth;
        end
    end

endmodule

// ===== tb/sv/entity_handle_allocator_mask_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the handle allocator: clock, reset, configuration, stimulus and verdict.
module entity_handle_allocator_mask_table_tb;
    import ehamt_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [OPCODE_W-1:0]    opcode;
    logic [ENTITY_W-1:0]    entity;
    logic [COMP_W-1:0]      component;
    logic                   done;
    logic [HANDLE_W-1:0]    handle;
    logic [STATUS_W-1:0]    status;
    logic                   present;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int                     fail_count;
    int                     pending;
    int                     used_slots;
    int                     stack_fill;
    int                     idle_pct;
    logic [CFG_DATA_W-1:0]  cur_mask;
    logic [COUNT_W-1:0]     cur_count;

    entity_handle_allocator_mask_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .entity    (entity),
        .component (component),
        .done      (done),
        .handle    (handle),
        .status    (status),
        .present   (present),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    entity_handle_allocator_mask_table_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .entity     (entity),
        .component  (component),
        .done       (done),
        .handle     (handle),
        .status     (status),
        .present    (present),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .used_slots (used_slots),
        .stack_fill (stack_fill)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #4000000;
        $display("entity_handle_allocator_mask_table test failed");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send(input logic [OPCODE_W-1:0] op, input logic [ENTITY_W-1:0] ent,
                        input logic [COMP_W-1:0] comp);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        entity <= ent;
        component <= comp;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] mask, input logic [COUNT_W-1:0] count);
        cfg_we <= 1'b1;
        cfg_index <= CFG_REG_MASK;
        cfg_wdata <= mask;
        @(negedge clk);
        cfg_index <= CFG_REG_COUNT;
        cfg_wdata <= CFG_DATA_W'(count);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_mask = mask;
        cur_count = count;
    endtask

    // mostly live-range handles and usable component ids, some raw noise
    task automatic random_ops(input int n);
        int                  r;
        logic [OPCODE_W-1:0] op;
        logic [ENTITY_W-1:0] ent;
        logic [COMP_W-1:0]   comp;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 18)
                op = OP_CREATE;
            else if (r < 32)
                op = OP_DESTROY;
            else if (r < 55)
                op = OP_ADD;
            else if (r < 67)
                op = OP_REMOVE;
            else if (r < 89)
                op = OP_HAS;
            else if (r < 93)
                op = OP_PURGE;
            else
                op = OPCODE_W'($urandom_range(0, 7));
            if (used_slots > 0 && r < 93 && $urandom_range(0, 9) != 0)
                ent = ENTITY_W'($urandom_range(0, used_slots - 1));
            else
                ent = ENTITY_W'($urandom_range(0, 255));
            if (cur_count > 0 && r < 93 && $urandom_range(0, 9) != 0)
                comp = COMP_W'($urandom_range(0, cur_count - 1));
            else
                comp = COMP_W'($urandom_range(0, 31));
            send(op, ent, comp);
        end
    endtask

    initial
    begin
        int fill;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_CREATE;
        entity = '0;
        component = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_REG_MASK;
        cfg_wdata = '0;
        idle_pct = 0;
        cur_mask = '0;
        cur_count = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_regs(32'h5555_5555, 5'd31);
        send(OP_DESTROY, 8'd0, 5'd0);
        send(OP_HAS, 8'd0, 5'd0);
        send(OP_CREATE, 8'hFF, 5'h1F);
        send(OP_CREATE, 8'd0, 5'd0);
        send(OP_ADD, 8'd0, 5'd0);
        send(OP_ADD, 8'd0, 5'd30);
        send(OP_HAS, 8'd0, 5'd30);
        send(OP_HAS, 8'd0, 5'd1);
        send(OP_ADD, 8'd0, 5'd1);
        send(OP_ADD, 8'd0, 5'd31);
        send(OP_REMOVE, 8'd1, 5'd0);
        send(OP_REMOVE, 8'd0, 5'd0);
        send(OP_DESTROY, 8'd1, 5'd0);
        send(OP_DESTROY, 8'd1, 5'd0);
        send(OP_HAS, 8'd1, 5'd30);
        send(OP_ADD, 8'd1, 5'd2);
        send(OP_CREATE, 8'd0, 5'd0);
        send(OP_HAS, 8'd1, 5'd2);
        send(OP_PURGE, 8'hFF, 5'd30);
        send(OP_HAS, 8'd0, 5'd30);
        send(OP_PURGE, 8'd0, 5'd31);
        send(OP_PURGE, 8'd0, 5'd3);
        send(OP_SPARE_A, 8'd0, 5'd0);
        send(OP_SPARE_B, 8'hFF, 5'h1F);
        send(OP_ADD, 8'hFF, 5'd0);
        settle();

        set_regs(32'hFFFF_FFFF, 5'd31);
        random_ops(120);
        settle();

        // use up every slot, then create on a full table
        idle_pct = 8;
        fill = (ENTITY_SLOTS_DEF - used_slots) + stack_fill;
        repeat (fill)
            send(OP_CREATE, ENTITY_W'($urandom), COMP_W'($urandom));
        send(OP_CREATE, 8'd0, 5'd0);
        send(OP_CREATE, 8'hFF, 5'h1F);
        send(OP_ADD, 8'hFF, 5'd30);
        send(OP_HAS, 8'hFF, 5'd30);
        send(OP_DESTROY, 8'hFF, 5'd0);
        send(OP_CREATE, 8'd0, 5'd0);
        send(OP_HAS, 8'hFF, 5'd30);
        settle();

        idle_pct = 59;
        set_regs(32'h0000_0000, 5'd0);
        random_ops(40);
        settle();

        set_regs(CFG_DATA_W'($urandom), COUNT_W'($urandom_range(1, 31)));
        repeat (2)
        begin
            random_ops(40);
            settle();
        end

        idle_pct = 8;
        set_regs(32'hFFFF_FFFF, 5'd31);
        random_ops(50);

        settle();
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("entity_handle_allocator_mask_table test passed");
        else
            $display("entity_handle_allocator_mask_table test failed");
        $finish;
    end

endmodule
